[design/tsq_pkg.sv]
// Package for the two-stack queue: widths, request/status codes, command word type.
// No dependencies; tsq_front, tsq_back and the top level refer to it by scoped names.
`default_nettype none
package tsq_pkg;

   localparam int unsigned DATA_W        = 32;
   localparam int unsigned STATUS_W      = 2;
   localparam int unsigned STACK_DEPTH_D = 128;

   localparam logic ACT_ENQ = 1'b0;
   localparam logic ACT_DEQ = 1'b1;

   localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

   localparam logic signed [DATA_W-1:0] EMPTY_ITEM = -32'sd1;
   localparam logic signed [DATA_W-1:0] ENQ_ITEM   = 32'sd0;

   typedef struct packed {
      logic                     deq;
      logic signed [DATA_W-1:0] value;
   } cmd_type;

endpackage
`default_nettype wire

[design/tsq_ram.sv]
// Generic simple dual-port RAM: one write port, one read port with registered read data.
// Uses no package; width and depth are parameters.
`default_nettype none
module tsq_ram #(
   parameter int unsigned WIDTH = 32,
   parameter int unsigned DEPTH = 128,
   localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic             rd_en,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

[design/tsq_front.sv]
// Front end: accepts request words, classifies them and holds them in a two-entry queue.
// Depends on tsq_pkg for the command word type and action codes.
`default_nettype none
module tsq_front (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_valid,
   output logic                                  req_ready,
   input  wire logic                             req_action,
   input  wire logic signed [tsq_pkg::DATA_W-1:0] req_value,
   output logic                                  cmd_valid,
   output tsq_pkg::cmd_type                      cmd,
   input  wire logic                             cmd_ready
);

   tsq_pkg::cmd_type entry_ff [2];
   logic             wr_ptr_ff, wr_ptr_in;
   logic             rd_ptr_ff, rd_ptr_in;
   logic [1:0]       cnt_ff, cnt_in;
   logic             push, pop;
   tsq_pkg::cmd_type new_cmd;

   assign req_ready = (cnt_ff != 2'd2);
   assign cmd_valid = (cnt_ff != 2'd0);
   assign cmd       = entry_ff[rd_ptr_ff];
   assign push      = req_valid && req_ready;
   assign pop       = cmd_valid && cmd_ready;

   always_comb begin
      new_cmd.deq   = (req_action == tsq_pkg::ACT_DEQ);
      new_cmd.value = req_value;
   end

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      cnt_in    = cnt_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= new_cmd;
      end
   end

endmodule
`default_nettype wire

[design/tsq_back.sv]
// Back end: runs commands against the input and output stacks, moves words across on
// demand and holds the result word in an output register. Depends on tsq_pkg, tsq_ram.
`default_nettype none
module tsq_back #(
   parameter int unsigned STACK_DEPTH = tsq_pkg::STACK_DEPTH_D
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              cmd_valid,
   input  wire tsq_pkg::cmd_type                  cmd,
   output logic                                   cmd_ready,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_ready,
   output logic signed [tsq_pkg::DATA_W-1:0]      rsp_item_out,
   output logic        [tsq_pkg::STATUS_W-1:0]    rsp_status
);

   localparam int unsigned AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
   localparam int unsigned CW = $clog2(STACK_DEPTH + 1);
   localparam logic [CW-1:0] FULL_CNT = CW'(STACK_DEPTH);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_XFER = 2'd1;
   localparam logic [1:0] S_WAIT = 2'd2;

   logic [1:0]    state_ff, state_in;
   logic [CW-1:0] in_cnt_ff, in_cnt_in;
   logic [CW-1:0] out_cnt_ff, out_cnt_in;
   logic          pend_ff, pend_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic signed [tsq_pkg::DATA_W-1:0]   rsp_item_ff, rsp_item_in;
   logic        [tsq_pkg::STATUS_W-1:0] rsp_status_ff, rsp_status_in;

   logic                        out_free, take;
   logic [CW-1:0]               in_top, out_top;
   logic                        in_we, in_re, out_we, out_re;
   logic [tsq_pkg::DATA_W-1:0]  in_rdata, out_rdata;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign cmd_ready = (state_ff == S_IDLE) && out_free;
   assign take      = cmd_valid && cmd_ready;
   assign in_top    = in_cnt_ff - 1'b1;
   assign out_top   = out_cnt_ff - 1'b1;

   tsq_ram #(.WIDTH(tsq_pkg::DATA_W), .DEPTH(STACK_DEPTH)) u_in_stack (
      .clock  (clock),
      .wr_en  (in_we),
      .wr_addr(in_cnt_ff[AW-1:0]),
      .wr_data(cmd.value),
      .rd_en  (in_re),
      .rd_addr(in_top[AW-1:0]),
      .rd_data(in_rdata)
   );

   tsq_ram #(.WIDTH(tsq_pkg::DATA_W), .DEPTH(STACK_DEPTH)) u_out_stack (
      .clock  (clock),
      .wr_en  (out_we),
      .wr_addr(out_cnt_ff[AW-1:0]),
      .wr_data(in_rdata),
      .rd_en  (out_re),
      .rd_addr(out_top[AW-1:0]),
      .rd_data(out_rdata)
   );

   always_comb begin
      state_in      = state_ff;
      in_cnt_in     = in_cnt_ff;
      out_cnt_in    = out_cnt_ff;
      pend_in       = 1'b0;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_item_in   = rsp_item_ff;
      rsp_status_in = rsp_status_ff;
      in_we         = 1'b0;
      in_re         = 1'b0;
      out_we        = 1'b0;
      out_re        = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (take) begin
               if (!cmd.deq) begin
                  rsp_valid_in = 1'b1;
                  rsp_item_in  = tsq_pkg::ENQ_ITEM;
                  if (in_cnt_ff == FULL_CNT) begin
                     rsp_status_in = tsq_pkg::STATUS_FULL;
                  end else begin
                     rsp_status_in = tsq_pkg::STATUS_OK;
                     in_we         = 1'b1;
                     in_cnt_in     = in_cnt_ff + 1'b1;
                  end
               end else if (in_cnt_ff == '0 && out_cnt_ff == '0) begin
                  rsp_valid_in  = 1'b1;
                  rsp_item_in   = tsq_pkg::EMPTY_ITEM;
                  rsp_status_in = tsq_pkg::STATUS_EMPTY;
               end else if (out_cnt_ff != '0) begin
                  out_re     = 1'b1;
                  out_cnt_in = out_top;
                  state_in   = S_WAIT;
               end else begin
                  state_in = S_XFER;
               end
            end
         end
         S_XFER: begin
            if (pend_ff) begin
               out_we     = 1'b1;
               out_cnt_in = out_cnt_ff + 1'b1;
            end
            if (in_cnt_ff != '0) begin
               in_re     = 1'b1;
               in_cnt_in = in_top;
               pend_in   = 1'b1;
            end else if (!pend_ff) begin
               out_re     = 1'b1;
               out_cnt_in = out_top;
               state_in   = S_WAIT;
            end
         end
         S_WAIT: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_item_in   = out_rdata;
               rsp_status_in = tsq_pkg::STATUS_OK;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         in_cnt_ff    <= '0;
         out_cnt_ff   <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         in_cnt_ff    <= in_cnt_in;
         out_cnt_ff   <= out_cnt_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_item_ff   <= rsp_item_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_item_out = rsp_item_ff;
   assign rsp_status   = rsp_status_ff;

   a_in_cnt_range: assert property (@(posedge clock) disable iff (reset)
      in_cnt_ff <= FULL_CNT)
      else $error("input stack count above depth");

   a_out_cnt_range: assert property (@(posedge clock) disable iff (reset)
      out_cnt_ff <= FULL_CNT)
      else $error("output stack count above depth");

   a_xfer_entry: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE && state_in == S_XFER) |-> (out_cnt_ff == '0 && in_cnt_ff != '0))
      else $error("transfer started with output stack loaded or input stack empty");

   a_xfer_no_pop_on_write: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_XFER && pend_ff) |-> !out_re)
      else $error("output stack read while a transfer write is pending");

   a_wait_holds_cmd: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_IDLE) |-> !cmd_ready)
      else $error("command taken while a dequeue is in progress");

endmodule
`default_nettype wire

[design/two_stack_queue_top.sv]
// Top level of the two-stack queue: front request queue feeding the stack engine.
// Depends on tsq_pkg, tsq_front, tsq_back (which holds two tsq_ram instances).
// Responses: rsp_valid is registered; an enqueue or an empty dequeue is answered from
// the command, a dequeue from a loaded output stack waits in S_WAIT for the RAM read,
// and one that must refill first moves the input words across in S_XFER via both RAMs.
// Throughput: one enqueue per cycle if responses are taken; none taken in S_XFER/S_WAIT.
// Reset (synchronous, active high) empties both stacks and the request queue; no sweep.
`default_nettype none
module two_stack_queue_top #(
   parameter int unsigned STACK_DEPTH = tsq_pkg::STACK_DEPTH_D
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_valid,
   output logic                                    req_ready,
   input  wire logic                               req_action,
   input  wire logic signed [tsq_pkg::DATA_W-1:0]  req_value,
   output logic                                    rsp_valid,
   input  wire logic                               rsp_ready,
   output logic signed [tsq_pkg::DATA_W-1:0]       rsp_item_out,
   output logic        [tsq_pkg::STATUS_W-1:0]     rsp_status
);

   logic             cmd_valid;
   logic             cmd_ready;
   tsq_pkg::cmd_type cmd;

   tsq_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_action(req_action),
      .req_value (req_value),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .cmd_ready (cmd_ready)
   );

   tsq_back #(.STACK_DEPTH(STACK_DEPTH)) u_back (
      .clock       (clock),
      .reset       (reset),
      .cmd_valid   (cmd_valid),
      .cmd         (cmd),
      .cmd_ready   (cmd_ready),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_item_out(rsp_item_out),
      .rsp_status  (rsp_status)
   );

endmodule
`default_nettype wire

[dv/testbench.sv]
// Testbench for two_stack_queue_top: random enqueue/dequeue traffic with bursty
// sender and stalling receiver, checked against a scoreboard that mirrors both stacks.
// Depends on tsq_pkg and two_stack_queue_top.
`timescale 1ns / 1ps
module testbench;

   localparam int unsigned DEPTH      = tsq_pkg::STACK_DEPTH_D;
   localparam int unsigned IDLE_LIMIT = 4000;
   localparam int unsigned HOLD_OFF   = 400;

   typedef struct packed {
      logic [tsq_pkg::DATA_W-1:0]   item;
      logic [tsq_pkg::STATUS_W-1:0] status;
   } outcome_type;

   class queue_scoreboard;
      logic [tsq_pkg::DATA_W-1:0] in_stack[DEPTH];
      logic [tsq_pkg::DATA_W-1:0] out_stack[DEPTH];
      int unsigned in_count = 0;
      int unsigned out_count = 0;
      outcome_type expected_outcomes[$];
      int unsigned errors = 0;
      int unsigned received = 0;

      function int unsigned pending();
         return expected_outcomes.size();
      endfunction

      function void note_request(logic act, logic [tsq_pkg::DATA_W-1:0] val);
         outcome_type o;
         o.item = tsq_pkg::ENQ_ITEM;
         o.status = tsq_pkg::STATUS_OK;
         if (act == tsq_pkg::ACT_ENQ) begin
            if (in_count >= DEPTH) begin
               o.status = tsq_pkg::STATUS_FULL;
            end else begin
               in_stack[in_count] = val;
               in_count++;
            end
         end else if (in_count == 0 && out_count == 0) begin
            o.item = tsq_pkg::EMPTY_ITEM;
            o.status = tsq_pkg::STATUS_EMPTY;
         end else begin
            if (out_count == 0) begin
               while (in_count > 0) begin
                  in_count--;
                  out_stack[out_count] = in_stack[in_count];
                  out_count++;
               end
            end
            out_count--;
            o.item = out_stack[out_count];
         end
         expected_outcomes.push_back(o);
      endfunction

      function void check_response(logic [tsq_pkg::DATA_W-1:0] item,
                                   logic [tsq_pkg::STATUS_W-1:0] status);
         outcome_type o;
         received++;
         if (expected_outcomes.size() == 0) begin
            $display("%0t: unexpected word: item %h status %0d", $time, item, status);
            errors++;
            return;
         end
         o = expected_outcomes.pop_front();
         if (item !== o.item) begin
            $display("%0t: item_out expected %h actual %h", $time, o.item, item);
            errors++;
         end
         if (status !== o.status) begin
            $display("%0t: status expected %0d actual %0d", $time, o.status, status);
            errors++;
         end
      endfunction
   endclass

   logic                                clock = 1'b0;
   logic                                reset = 1'b1;
   logic                                req_valid = 1'b0;
   logic                                req_ready;
   logic                                req_action = tsq_pkg::ACT_ENQ;
   logic signed [tsq_pkg::DATA_W-1:0]   req_value = '0;
   logic                                rsp_valid;
   logic                                rsp_ready = 1'b0;
   logic signed [tsq_pkg::DATA_W-1:0]   rsp_item_out;
   logic        [tsq_pkg::STATUS_W-1:0] rsp_status;

   queue_scoreboard sb = new;
   int unsigned burst_left = 0;

   two_stack_queue_top dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_action   (req_action),
      .req_value    (req_value),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_item_out (rsp_item_out),
      .rsp_status   (rsp_status)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   function automatic logic [tsq_pkg::DATA_W-1:0] pick_value();
      case ($urandom_range(0, 9))
         0: return 32'h8000_0000;
         1: return 32'h7fff_ffff;
         2: return 32'h0000_0000;
         3: return 32'hffff_ffff;
         default: return $urandom;
      endcase
   endfunction

   task automatic send_word(input logic act, input logic [tsq_pkg::DATA_W-1:0] val);
      int unsigned gap;
      @(negedge clock);
      if (burst_left == 0) begin
         gap = $urandom_range(1, 6);
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(50, 200)
                                                  : $urandom_range(1, 16);
      end
      req_valid <= 1'b1;
      req_action <= act;
      req_value <= val;
      burst_left--;
      do @(posedge clock); while (!req_ready);
      sb.note_request(act, val);
   endtask

   task automatic run_random(input int unsigned total);
      int unsigned enq_pct[6] = '{60, 100, 25, 90, 5, 75};
      int unsigned n;
      int unsigned phase;
      int unsigned left;
      int unsigned pct;
      logic act;
      n = 0;
      phase = 0;
      while (n < total) begin
         pct = enq_pct[phase % 6];
         left = (pct == 100) ? $urandom_range(140, 200) : $urandom_range(40, 200);
         phase++;
         while (left > 0 && n < total) begin
            if (n == total / 2) begin
               // drain everything before going on
               @(negedge clock);
               req_valid <= 1'b0;
               while (sb.pending() != 0) @(negedge clock);
               burst_left = 0;
            end
            act = ($urandom_range(1, 100) <= pct) ? tsq_pkg::ACT_ENQ : tsq_pkg::ACT_DEQ;
            send_word(act, pick_value());
            n++;
            left--;
         end
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         sb.check_response(rsp_item_out, rsp_status);
      end
   end

   initial begin
      int unsigned seg_len;
      int unsigned mode;
      int unsigned period;
      int unsigned i;
      bit held;
      held = 1'b0;
      wait (!reset);
      forever begin
         seg_len = $urandom_range(20, 150);
         mode = $urandom_range(0, 2);
         period = $urandom_range(2, 5);
         for (i = 0; i < seg_len; i++) begin
            @(negedge clock);
            case (mode)
               0: rsp_ready <= 1'b1;
               1: rsp_ready <= (i % period) != 0;
               default: rsp_ready <= 1'($urandom_range(0, 1));
            endcase
         end
         if (!held && sb.received >= 200) begin
            // hold off long enough for the block to back up
            held = 1'b1;
            @(negedge clock);
            rsp_ready <= 1'b0;
            repeat (HOLD_OFF) @(negedge clock);
         end
      end
   end

   initial begin
      int unsigned idle;
      idle = 0;
      while (idle < IDLE_LIMIT) begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
            idle = 0;
         end else begin
            idle++;
         end
      end
      $display("Mismatches found");
      $finish;
   end

   initial begin
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      send_word(tsq_pkg::ACT_DEQ, 32'h1234_5678);
      send_word(tsq_pkg::ACT_ENQ, 32'h8000_0000);
      send_word(tsq_pkg::ACT_ENQ, 32'h7fff_ffff);
      send_word(tsq_pkg::ACT_DEQ, 32'h0000_0000);
      send_word(tsq_pkg::ACT_ENQ, 32'h0000_0000);
      send_word(tsq_pkg::ACT_ENQ, 32'hffff_ffff);
      send_word(tsq_pkg::ACT_DEQ, 32'hffff_ffff);
      send_word(tsq_pkg::ACT_DEQ, 32'h0000_0000);
      send_word(tsq_pkg::ACT_DEQ, 32'h0000_0000);
      send_word(tsq_pkg::ACT_DEQ, 32'h0000_0000);
      send_word(tsq_pkg::ACT_ENQ, 32'h0000_0001);
      send_word(tsq_pkg::ACT_ENQ, 32'hfffe_fffe);
      send_word(tsq_pkg::ACT_DEQ, 32'h0000_0000);
      send_word(tsq_pkg::ACT_ENQ, 32'h5555_aaaa);
      send_word(tsq_pkg::ACT_DEQ, 32'h0000_0000);
      send_word(tsq_pkg::ACT_DEQ, 32'h0000_0000);
      send_word(tsq_pkg::ACT_DEQ, 32'h0000_0000);

      run_random(1350);

      @(negedge clock);
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (20) @(posedge clock);

      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end
endmodule
